// ----- rtl/core/afd_pkg.sv -----
// Shared constants and types for the accelerometer fall detector
`timescale 1ns / 1ps

package afd_pkg;

  localparam int SAMPLE_BITS_DEFAULT = 13;
  localparam int MAG_W               = 26;
  localparam int CFG_IDX_W           = 3;
  localparam int COUNT_W             = 3;

  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  localparam logic [MAG_W-1:0] LOW_LEVEL_RST      = MAG_W'(200000);
  localparam logic [MAG_W-1:0] VERY_LOW_LEVEL_RST = MAG_W'(40000);
  localparam logic [MAG_W-1:0] IMPACT_LEVEL_RST   = MAG_W'(10000000);
  localparam logic [MAG_W-1:0] NORMAL_FLOOR_RST   = MAG_W'(800000);
  localparam logic [MAG_W-1:0] NORMAL_CEILING_RST = MAG_W'(1200000);

  localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERY_LOW_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMPACT_LEVEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_FLOOR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_CEILING = 3'd4;

  localparam logic [COUNT_W-1:0] FREE_FALL_COUNT = 3'd4;
  localparam logic [COUNT_W-1:0] SETTLE_SAMPLES  = 3'd4;
  localparam logic [COUNT_W-1:0] NORMAL_SAMPLES  = 3'd4;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 3'd7;

  typedef struct packed {
    logic             valid;
    logic [MAG_W-1:0] value;
  } mag_item_t;

endpackage

// ----- rtl/core/afd_magnitude.sv -----
// Sample register and saturated sum of squares
`timescale 1ns / 1ps

module afd_magnitude #(
  parameter int SAMPLE_BITS = afd_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] accel_x,
  input  logic signed [SAMPLE_BITS-1:0] accel_y,
  input  logic signed [SAMPLE_BITS-1:0] accel_z,
  output afd_pkg::mag_item_t            mag,
  input  logic                          mag_ready
);

  localparam int SQ_W  = 2 * SAMPLE_BITS;
  localparam int SUM_W = SQ_W + 2;
  localparam int CMP_W = (SUM_W > afd_pkg::MAG_W) ? SUM_W : afd_pkg::MAG_W;

  logic                   smp_valid;
  logic [SAMPLE_BITS-1:0] smp_x;
  logic [SAMPLE_BITS-1:0] smp_y;
  logic [SAMPLE_BITS-1:0] smp_z;
  logic [SQ_W-1:0]        sq_x;
  logic [SQ_W-1:0]        sq_y;
  logic [SQ_W-1:0]        sq_z;
  logic                   smp_ready;
  logic [SAMPLE_BITS-1:0] abs_x;
  logic [SAMPLE_BITS-1:0] abs_y;
  logic [SAMPLE_BITS-1:0] abs_z;
  logic [SUM_W-1:0]       sum;
  logic [CMP_W-1:0]       sum_ext;

  assign smp_ready = !smp_valid || mag_ready;
  assign in_stall  = !smp_ready;

  assign abs_x = smp_x[SAMPLE_BITS-1] ? (~smp_x + 1'b1) : smp_x;
  assign abs_y = smp_y[SAMPLE_BITS-1] ? (~smp_y + 1'b1) : smp_y;
  assign abs_z = smp_z[SAMPLE_BITS-1] ? (~smp_z + 1'b1) : smp_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (smp_ready) begin
      smp_valid <= in_valid;
    end
    if (smp_ready && in_valid) begin
      smp_x <= $unsigned(accel_x);
      smp_y <= $unsigned(accel_y);
      smp_z <= $unsigned(accel_z);
    end
  end

  assign sq_x = SQ_W'(abs_x) * SQ_W'(abs_x);
  assign sq_y = SQ_W'(abs_y) * SQ_W'(abs_y);
  assign sq_z = SQ_W'(abs_z) * SQ_W'(abs_z);

  assign sum     = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
  assign sum_ext = CMP_W'(sum);

  always_comb begin
    mag.valid = smp_valid;
    if (sum_ext > CMP_W'(afd_pkg::MAG_MAX)) begin
      mag.value = afd_pkg::MAG_MAX;
    end else begin
      mag.value = sum_ext[afd_pkg::MAG_W-1:0];
    end
  end

endmodule

// ----- rtl/core/afd_detector.sv -----
// Threshold registers, fall sequence state and result register
`timescale 1ns / 1ps

module afd_detector (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [afd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [afd_pkg::MAG_W-1:0]        cfg_data,
  input  afd_pkg::mag_item_t               mag,
  output logic                             mag_ready,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [afd_pkg::MAG_W-1:0]        magnitude_sq,
  output logic                             free_fall,
  output logic                             impact,
  output logic                             fall_detected
);

  logic [afd_pkg::MAG_W-1:0]   low_level;
  logic [afd_pkg::MAG_W-1:0]   very_low_level;
  logic [afd_pkg::MAG_W-1:0]   impact_level;
  logic [afd_pkg::MAG_W-1:0]   normal_floor;
  logic [afd_pkg::MAG_W-1:0]   normal_ceiling;

  logic [afd_pkg::COUNT_W-1:0] possible_fall_count;
  logic                        free_fall_flag;
  logic                        impact_flag;
  logic [afd_pkg::COUNT_W-1:0] settle_count;
  logic [afd_pkg::COUNT_W-1:0] normal_count;

  logic [afd_pkg::COUNT_W-1:0] possible_fall_count_next;
  logic                        free_fall_flag_next;
  logic                        impact_flag_next;
  logic [afd_pkg::COUNT_W-1:0] settle_count_next;
  logic [afd_pkg::COUNT_W-1:0] normal_count_next;
  logic                        fall_next;
  logic                        load;

  function automatic logic [afd_pkg::COUNT_W-1:0] sat_inc(
    input logic [afd_pkg::COUNT_W-1:0] c
  );
    return (c < afd_pkg::COUNT_MAX) ? c + 1'b1 : afd_pkg::COUNT_MAX;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      low_level      <= afd_pkg::LOW_LEVEL_RST;
      very_low_level <= afd_pkg::VERY_LOW_LEVEL_RST;
      impact_level   <= afd_pkg::IMPACT_LEVEL_RST;
      normal_floor   <= afd_pkg::NORMAL_FLOOR_RST;
      normal_ceiling <= afd_pkg::NORMAL_CEILING_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        afd_pkg::REG_LOW_LEVEL:      low_level      <= cfg_data;
        afd_pkg::REG_VERY_LOW_LEVEL: very_low_level <= cfg_data;
        afd_pkg::REG_IMPACT_LEVEL:   impact_level   <= cfg_data;
        afd_pkg::REG_NORMAL_FLOOR:   normal_floor   <= cfg_data;
        afd_pkg::REG_NORMAL_CEILING: normal_ceiling <= cfg_data;
        default: ;
      endcase
    end
  end

  assign mag_ready = !out_valid || !out_stall;
  assign load      = mag.valid && mag_ready;

  always_comb begin
    possible_fall_count_next = possible_fall_count;
    free_fall_flag_next      = free_fall_flag;
    settle_count_next        = settle_count;
    normal_count_next        = normal_count;
    fall_next                = 1'b0;

    if (mag.value < low_level) begin
      if (possible_fall_count == '0) begin
        possible_fall_count_next = 3'd1;
      end
      if (mag.value < very_low_level) begin
        possible_fall_count_next = sat_inc(possible_fall_count_next);
      end
      if (possible_fall_count_next == afd_pkg::FREE_FALL_COUNT) begin
        free_fall_flag_next = 1'b1;
      end
    end else begin
      possible_fall_count_next = '0;
    end

    impact_flag_next = impact_flag || (free_fall_flag_next && (mag.value > impact_level));

    if (impact_flag_next) begin
      settle_count_next = sat_inc(settle_count);
      if (settle_count_next > afd_pkg::SETTLE_SAMPLES) begin
        if ((mag.value < normal_ceiling) && (mag.value > normal_floor)) begin
          normal_count_next = sat_inc(normal_count);
        end else begin
          normal_count_next = '0;
        end
      end
      if (normal_count_next > afd_pkg::NORMAL_SAMPLES) begin
        fall_next                = 1'b1;
        possible_fall_count_next = '0;
        free_fall_flag_next      = 1'b0;
        impact_flag_next         = 1'b0;
        settle_count_next        = '0;
        normal_count_next        = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      possible_fall_count <= '0;
      free_fall_flag      <= 1'b0;
      impact_flag         <= 1'b0;
      settle_count        <= '0;
      normal_count        <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (load) begin
        possible_fall_count <= possible_fall_count_next;
        free_fall_flag      <= free_fall_flag_next;
        impact_flag         <= impact_flag_next;
        settle_count        <= settle_count_next;
        normal_count        <= normal_count_next;
      end
      if (mag_ready) begin
        out_valid <= mag.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      magnitude_sq  <= mag.value;
      free_fall     <= free_fall_flag_next;
      impact        <= impact_flag_next;
      fall_detected <= fall_next;
    end
  end

  a_fall_clears_flags: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fall_detected) |-> (!free_fall && !impact))
    else $error("fall reported with flags still set");

  a_fall_clears_state: assert property (@(posedge clk) disable iff (rst)
    (load && fall_next) |=> ((possible_fall_count == '0) && !free_fall_flag &&
                             !impact_flag && (settle_count == '0) && (normal_count == '0)))
    else $error("state not cleared after fall");

  a_impact_needs_free_fall: assert property (@(posedge clk) disable iff (rst)
    impact_flag |-> free_fall_flag)
    else $error("impact latched without free fall");

  a_counts_idle_before_impact: assert property (@(posedge clk) disable iff (rst)
    !impact_flag |-> ((settle_count == '0) && (normal_count == '0)))
    else $error("settle or normal count moved before impact");

  a_normal_after_settle: assert property (@(posedge clk) disable iff (rst)
    (normal_count != '0) |-> (settle_count > afd_pkg::SETTLE_SAMPLES))
    else $error("normal count advanced during settling");

endmodule

// ----- rtl/core/accel_fall_detector.sv -----
// Top level of the accelerometer fall detector
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  accel_x, accel_y, accel_z
//   out      output     out_valid / out_stall magnitude_sq, free_fall, impact, fall_detected
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// One item per cycle while out_stall is low; each item passes through the sample
// register and then the result register.
// The three squares, their sum, the compares and the counter update all sit
// between the sample register and the result register.
// Reset clears the pipeline, the sequence state and loads the default thresholds.
// out_stall holds the result; each stage still takes an item while the one after
// it has room, so in_stall rises only when every stage is full.
`timescale 1ns / 1ps

module accel_fall_detector #(
  parameter int SAMPLE_BITS = afd_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [afd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afd_pkg::MAG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] accel_x,
  input  logic signed [SAMPLE_BITS-1:0] accel_y,
  input  logic signed [SAMPLE_BITS-1:0] accel_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [afd_pkg::MAG_W-1:0]     magnitude_sq,
  output logic                          free_fall,
  output logic                          impact,
  output logic                          fall_detected
);

  afd_pkg::mag_item_t mag;
  logic               mag_ready;

  afd_magnitude #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_magnitude (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .accel_x   (accel_x),
    .accel_y   (accel_y),
    .accel_z   (accel_z),
    .mag       (mag),
    .mag_ready (mag_ready)
  );

  afd_detector u_detector (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mag           (mag),
    .mag_ready     (mag_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .magnitude_sq  (magnitude_sq),
    .free_fall     (free_fall),
    .impact        (impact),
    .fall_detected (fall_detected)
  );

endmodule
